/* design/kps_pkg.sv */
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types, constants and the keymap for the keypad scanner.
// ----------------------------------------------------------------------------
package kps_pkg;

  localparam int unsigned NumRows     = 4;
  localparam int unsigned MaskW       = 12;
  localparam int unsigned CodeW       = 7;
  localparam int unsigned CountW      = 4;
  localparam int unsigned EventCntW   = 4;

  localparam logic [MaskW-1:0]     ComboReset  = 12'h121;
  localparam logic [CountW-1:0]    RepeatFirst = 4'd11;
  localparam logic [CountW-1:0]    RepeatAgain = 4'd14;
  localparam logic [CountW-1:0]    RepeatWrap  = 4'd10;
  localparam logic [EventCntW-1:0] MaxEvents   = 4'd11;

  // Commands from the sequencer to the bit scan unit.
  typedef struct packed {
    logic load;
    logic step;
  } kps_scan_ctl_t;

  // Status from the bit scan unit.
  typedef struct packed {
    logic hit;         // bit under the index is set
    logic rest_empty;  // nothing left once that bit is cleared
  } kps_scan_stat_t;

  // Key index to ASCII; indexes past the 3x4 pad map to zero.
  function automatic logic [CodeW-1:0] kps_keymap(input logic [3:0] idx);
    logic [CodeW-1:0] code;
    case (idx)
      4'd0:    code = 7'h23;  // '#'
      4'd1:    code = 7'h39;  // '9'
      4'd2:    code = 7'h36;  // '6'
      4'd3:    code = 7'h33;  // '3'
      4'd4:    code = 7'h30;  // '0'
      4'd5:    code = 7'h38;  // '8'
      4'd6:    code = 7'h35;  // '5'
      4'd7:    code = 7'h32;  // '2'
      4'd8:    code = 7'h2A;  // '*'
      4'd9:    code = 7'h37;  // '7'
      4'd10:   code = 7'h34;  // '4'
      4'd11:   code = 7'h31;  // '1'
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

/* design/kps_bit_scan.sv */
// ----------------------------------------------------------------------------
// kps_bit_scan
// Walks a loaded key bitmap one bit per step, ascending, clearing as it goes.
// ----------------------------------------------------------------------------
module kps_bit_scan
  import kps_pkg::*;
#(
  parameter int unsigned FrameW = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kps_scan_ctl_t              ctl_i,
  input  logic [FrameW-1:0]          load_bits_i,
  output kps_scan_stat_t             stat_o,
  output logic [$clog2(FrameW)-1:0]  idx_o
);

  localparam int unsigned IdxW = $clog2(FrameW);

  logic [FrameW-1:0] rem_q, rem_d, rest;
  logic [IdxW-1:0]   idx_q, idx_d;

  assign rest = rem_q & ~(FrameW'(1) << idx_q);

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (ctl_i.load) begin
      rem_d = load_bits_i;
      idx_d = '0;
    end else if (ctl_i.step) begin
      rem_d = rest;
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  assign stat_o.hit        = rem_q[idx_q];
  assign stat_o.rest_empty = (rest == '0);
  assign idx_o             = idx_q;

endmodule

/* design/matrix_keypad_scanner_autorepeat_core.sv */
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_autorepeat_core
// Matrix keypad scanner: column drive, frame capture, new-key and auto-repeat
// events, reset-combination detect.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                | Payload
//  --------+--------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o  | row_levels_i (one scan tick)
//  out     | out_valid_o / out_ready_i| drive_column_o, key_valid_o,
//          |                          | key_code_o, reset_request_o,
//          |                          | last_of_run_o
//  cfg     | cfg_we_i                 | cfg_wdata_i -> reset combo mask
//
// A tick is accepted in ST_IDLE; ST_STEP then updates state and loads the
// output register. A frame end with newly pressed keys then runs the bit
// scan unit one key index per cycle, up to the highest new key, except
// while a new key must go out and the output register is held.
// Reset (rst_ni, async) clears the scanner and sets the mask to 0x121.
// The sequencer only advances into the output register when it is empty or
// being drained, so downstream stalls simply freeze the scan.
//
module matrix_keypad_scanner_autorepeat_core
  import kps_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config
  input  logic               cfg_we_i,
  input  logic [MaskW-1:0]   cfg_wdata_i,
  // scan tick in
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [NumRows-1:0] row_levels_i,
  // events out
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         drive_column_o,
  output logic               key_valid_o,
  output logic [CodeW-1:0]   key_code_o,
  output logic               reset_request_o,
  output logic               last_of_run_o
);

  localparam int unsigned FrameW = NUM_COLUMNS * NumRows;
  localparam int unsigned IdxW   = $clog2(FrameW);
  localparam int unsigned PhaseW = $clog2(2 * NUM_COLUMNS);
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(2 * NUM_COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [MaskW-1:0]     mask_q;
  logic [NumRows-1:0]   rows_q;
  logic [PhaseW-1:0]    phase_q, phase_d;
  logic [1:0]           col_q, col_d;
  logic [FrameW-1:0]    frame_q, frame_d;
  logic [FrameW-1:0]    prev_q, prev_d;
  logic                 rep_act_q, rep_act_d;
  logic [IdxW-1:0]      rep_key_q, rep_key_d;
  logic [CountW-1:0]    rep_cnt_q, rep_cnt_d;
  logic [EventCntW-1:0] nev_q, nev_d;

  // output register
  logic                 out_valid_q;
  logic [1:0]           o_col_q, o_col_d;
  logic                 o_kv_q, o_kv_d;
  logic [CodeW-1:0]     o_code_q, o_code_d;
  logic                 o_rst_q, o_rst_d;
  logic                 o_last_q, o_last_d;
  logic                 out_load;
  logic                 out_free;

  // tick datapath
  logic [1:0]           col_n;
  logic [FrameW-1:0]    frame_n, keys, delta, fresh, mask_x;
  logic                 frame_end, combo_hit;
  logic [CountW-1:0]    rep_t;

  // bit scan unit
  kps_scan_ctl_t        scan_ctl;
  kps_scan_stat_t       scan_stat;
  logic [IdxW-1:0]      scan_idx;

  kps_bit_scan #(
    .FrameW (FrameW)
  ) u_bit_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .load_bits_i (fresh),
    .stat_o      (scan_stat),
    .idx_o       (scan_idx)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Even phase picks the column, odd phase shifts the rows in.
  assign col_n     = phase_q[0] ? col_q : 2'(phase_q >> 1);
  assign frame_n   = phase_q[0] ? {frame_q[FrameW-NumRows-1:0], rows_q} : frame_q;
  assign frame_end = (phase_q == PhaseLast);
  assign keys      = ~frame_n;
  assign mask_x    = FrameW'(mask_q);
  assign combo_hit = (mask_q != '0) && ((keys & mask_x) == mask_x);
  assign delta     = prev_q ^ keys;
  assign fresh     = delta & keys;
  assign rep_t     = rep_cnt_q + CountW'(1);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    col_d     = col_q;
    frame_d   = frame_q;
    prev_d    = prev_q;
    rep_act_d = rep_act_q;
    rep_key_d = rep_key_q;
    rep_cnt_d = rep_cnt_q;
    nev_d     = nev_q;
    scan_ctl  = '0;
    out_load  = 1'b0;
    o_col_d   = col_n;
    o_kv_d    = 1'b0;
    o_code_d  = '0;
    o_rst_d   = 1'b0;
    o_last_d  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_STEP;
        end
      end

      ST_STEP: begin
        if (out_free) begin
          col_d   = col_n;
          frame_d = frame_n;
          state_d = ST_IDLE;
          if (!frame_end) begin
            phase_d  = phase_q + PhaseW'(1);
            out_load = 1'b1;
          end else if (combo_hit) begin
            // reset combination held: flag it and clear the scanner
            phase_d   = '0;
            col_d     = '0;
            frame_d   = '0;
            prev_d    = '0;
            rep_act_d = 1'b0;
            rep_key_d = '0;
            rep_cnt_d = '0;
            o_rst_d   = 1'b1;
            out_load  = 1'b1;
          end else begin
            phase_d = '0;
            prev_d  = keys;
            frame_d = '0;
            if (fresh != '0) begin
              rep_act_d     = 1'b1;
              rep_cnt_d     = '0;
              nev_d         = '0;
              scan_ctl.load = 1'b1;
              state_d       = ST_SCAN;
            end else if (rep_act_q && delta[rep_key_q]) begin
              // repeat key released
              rep_act_d = 1'b0;
              rep_cnt_d = '0;
              out_load  = 1'b1;
            end else if (rep_act_q) begin
              out_load  = 1'b1;
              rep_cnt_d = rep_t;
              if (rep_t == RepeatFirst || rep_t == RepeatAgain) begin
                o_kv_d   = 1'b1;
                o_code_d = kps_keymap(4'(rep_key_q));
              end
              if (rep_t == RepeatAgain) begin
                rep_cnt_d = RepeatWrap;
              end
            end else begin
              out_load = 1'b1;
            end
          end
        end
      end

      ST_SCAN: begin
        o_col_d  = col_q;
        o_kv_d   = 1'b1;
        o_code_d = kps_keymap(4'(scan_idx));
        o_last_d = scan_stat.rest_empty || (nev_q == MaxEvents - EventCntW'(1));
        // hold only when a key must go out and the output is occupied
        if (!(scan_stat.hit && (nev_q < MaxEvents) && !out_free)) begin
          scan_ctl.step = 1'b1;
          if (scan_stat.hit) begin
            rep_key_d = scan_idx;  // highest new key wins
            if (nev_q < MaxEvents) begin
              out_load = 1'b1;
              nev_d    = nev_q + EventCntW'(1);
            end
            if (scan_stat.rest_empty) begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mask_q      <= ComboReset;
      phase_q     <= '0;
      col_q       <= '0;
      frame_q     <= '0;
      prev_q      <= '0;
      rep_act_q   <= 1'b0;
      rep_key_q   <= '0;
      rep_cnt_q   <= '0;
      nev_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      col_q     <= col_d;
      frame_q   <= frame_d;
      prev_q    <= prev_d;
      rep_act_q <= rep_act_d;
      rep_key_q <= rep_key_d;
      rep_cnt_q <= rep_cnt_d;
      nev_q     <= nev_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      rows_q <= row_levels_i;
    end
    if (out_load) begin
      o_col_q  <= o_col_d;
      o_kv_q   <= o_kv_d;
      o_code_q <= o_code_d;
      o_rst_q  <= o_rst_d;
      o_last_q <= o_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_column_o  = o_col_q;
  assign key_valid_o     = o_kv_q;
  assign key_code_o      = o_code_q;
  assign reset_request_o = o_rst_q;
  assign last_of_run_o   = o_last_q;

endmodule
